// ----- rtl/core/single_source_shortest_path_macros.svh -----
// Assertion macros for the shortest path block.
// Used by the top level only; no other dependencies.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSSP_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sssp check failed");
// next-cycle implication
`define SSSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sssp check failed");
`else
`define SSSP_ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define SSSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/sssp_pkg.sv -----
// Shared types and constants for the shortest path block.
// No dependencies; imported by every module of the block.
package sssp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam int VERTEX_BITS    = 6;
   localparam int WEIGHT_IN_BITS = 16;
   localparam int DIST_BITS      = 22;
   localparam int CFG_COUNT_BITS = 7;
   localparam int CSR_DATA_BITS  = 7;

   typedef enum logic [0:0] {
      CSR_VERTEX_COUNT  = 1'b0,
      CSR_SOURCE_VERTEX = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]    edge_from;
      logic [VERTEX_BITS-1:0]    edge_to;
      logic [WEIGHT_IN_BITS-1:0] edge_weight;
      logic                      has_edge;
      logic                      last_edge;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] vertex_index;
      logic [DIST_BITS-1:0]   path_distance;
      logic [VERTEX_BITS-1:0] predecessor;
      logic                   has_predecessor;
      logic                   reachable;
      logic                   edges_dropped;
      logic                   last_result;
   } rsp_type;

   typedef enum logic [0:0] {
      ALU_ADD_SAT = 1'b0,
      ALU_LESS    = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [DIST_BITS-1:0] opa;
      logic [DIST_BITS-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] sum;
      logic                 less;
   } alu_rsp_type;

endpackage

// ----- rtl/core/sssp_alu.sv -----
// Shared distance unit: saturating add or less-than compare.
// Depends on sssp_pkg.
module sssp_alu
   import sssp_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [DIST_BITS:0] wide_sum;

   always_comb begin
      wide_sum = {1'b0, req.opa} + {1'b0, req.opb};
      rsp.sum  = '0;
      rsp.less = 1'b0;
      unique case (req.op)
         ALU_ADD_SAT: begin
            // carry out means the sum passed the largest distance
            rsp.sum = wide_sum[DIST_BITS] ? '1 : wide_sum[DIST_BITS-1:0];
         end
         ALU_LESS: begin
            rsp.less = req.opa < req.opb;
         end
         default: begin
            rsp.sum  = '0;
            rsp.less = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/core/sssp_edge_store.sv -----
// Edge memory: one write port, one read port with registered data.
// Depends on sssp_pkg for defaults.
module sssp_edge_store
   import sssp_pkg::*;
#(
   parameter  int DEPTH      = MAX_EDGES_DEF,
   parameter  int ENTRY_BITS = 2 * VERTEX_BITS + WEIGHT_BITS_DEF,
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [ENTRY_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [ENTRY_BITS-1:0] rd_data
);

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sssp_vertex_table.sv -----
// Per-vertex distance and predecessor memory, registered read.
// Depends on sssp_pkg.
module sssp_vertex_table
   import sssp_pkg::*;
#(
   parameter  int VERTICES = MAX_VERTICES_DEF,
   localparam int AW       = $clog2(VERTICES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DIST_BITS-1:0] wr_dist,
   input  logic [AW-1:0]        wr_pred,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [DIST_BITS-1:0] rd_dist,
   output logic [AW-1:0]        rd_pred
);

   logic [DIST_BITS-1:0] dist_mem [VERTICES];
   logic [AW-1:0]        pred_mem [VERTICES];
   logic [DIST_BITS-1:0] rd_dist_ff;
   logic [AW-1:0]        rd_pred_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= wr_dist;
         pred_mem[wr_addr] <= wr_pred;
      end
      if (rd_en) begin
         rd_dist_ff <= dist_mem[rd_addr];
         rd_pred_ff <= pred_mem[rd_addr];
      end
   end

   assign rd_dist = rd_dist_ff;
   assign rd_pred = rd_pred_ff;

endmodule

// ----- rtl/core/single_source_shortest_path.sv -----
// Top level of the shortest path block: sequencer, marks, config, result reg.
// Depends on sssp_pkg, sssp_alu, sssp_edge_store, sssp_vertex_table, macros.
//
//   channel  ports                          handshake
//   -------  -----------------------------  -------------------------------
//   request  start, busy, req_data          taken when start && !busy
//   result   rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//   config   csr_wr_en, csr_index, csr_wdata write when csr_wr_en, no wait
//
// Edge items load at one per cycle; busy stays low while loading.
// After the last item: an init step, then per settled vertex a scan of
// the N table entries, a settle step, a read and check of each stored
// edge (plus a sum and an update for an edge from the settled vertex to
// an unsettled head in range) and a closing step; then a final scan and
// one result per vertex, each after a table read. N is the active vertex
// count. Each scan step is a table read state, then a compare state.
// Reset is synchronous; no clearing pass is needed. Results cannot stall.
`include "single_source_shortest_path_macros.svh"
module single_source_shortest_path
   import sssp_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // vertex index, vertex counter, edge counter and edge address widths
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   // stored weight: input is cut to the smaller of WEIGHT_BITS and WEIGHT_IN_BITS
   localparam int WB  = (WEIGHT_BITS < WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
   localparam int ENTRY_BITS = 2 * VW + WB;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SEL_RD,
      ST_SEL_CMP,
      ST_SETTLE,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_EDGE_SUM,
      ST_EDGE_UPD,
      ST_OUT_RD,
      ST_OUT_EMIT
   } state_type;

   // control state
   state_type                 state_ff, state_in;
   logic [CFG_COUNT_BITS-1:0] vcount_ff, vcount_in;
   logic [VERTEX_BITS-1:0]    source_ff, source_in;
   logic [EW-1:0]             edge_total_ff, edge_total_in;
   logic                      drop_ff, drop_in;
   logic [MAX_VERTICES-1:0]   settled_ff, settled_in;
   logic [MAX_VERTICES-1:0]   reached_ff, reached_in;
   logic [MAX_VERTICES-1:0]   predv_ff, predv_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic                      found_ff, found_in;
   logic [EW-1:0]             edge_idx_ff, edge_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   // payload
   logic [VW-1:0]             best_idx_ff, best_idx_in;
   logic [DIST_BITS-1:0]      best_dist_ff, best_dist_in;
   logic [DIST_BITS-1:0]      sum_ff, sum_in;
   rsp_type                   rsp_ff, rsp_in;

   // memory and unit hookups
   logic                  edge_we, edge_re;
   logic [EAW-1:0]        edge_waddr, edge_raddr;
   logic [ENTRY_BITS-1:0] edge_wdata, edge_rdata;
   logic [VW-1:0]         e_from, e_to;
   logic [WB-1:0]         e_w;

   logic                  vt_we, vt_re;
   logic [VW-1:0]         vt_waddr, vt_raddr, vt_wpred, vt_rpred;
   logic [DIST_BITS-1:0]  vt_wdist, vt_rdist;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;

   logic [CW-1:0]             n_eff;
   logic [CFG_COUNT_BITS-1:0] n_ext;
   logic                      accept;
   logic [VW-1:0]             cur;
   logic                      cand;
   logic                      reach_out;
   logic                      hp_out;

   assign {e_from, e_to, e_w} = edge_rdata;

   // a count above capacity acts as the capacity
   assign n_eff  = (vcount_ff > CFG_COUNT_BITS'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                              : vcount_ff[CW-1:0];
   assign n_ext  = CFG_COUNT_BITS'(n_eff);
   assign accept = start && (state_ff == ST_IDLE);
   assign cur    = idx_ff[VW-1:0];
   assign busy   = (state_ff != ST_IDLE);

   sssp_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   sssp_edge_store #(
      .DEPTH      (MAX_EDGES),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_edges (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_en   (edge_re),
      .rd_addr (edge_raddr),
      .rd_data (edge_rdata)
   );

   sssp_vertex_table #(
      .VERTICES (MAX_VERTICES)
   ) u_table (
      .clock   (clock),
      .wr_en   (vt_we),
      .wr_addr (vt_waddr),
      .wr_dist (vt_wdist),
      .wr_pred (vt_wpred),
      .rd_en   (vt_re),
      .rd_addr (vt_raddr),
      .rd_dist (vt_rdist),
      .rd_pred (vt_rpred)
   );

   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      source_in     = source_ff;
      edge_total_in = edge_total_ff;
      drop_in       = drop_ff;
      settled_in    = settled_ff;
      reached_in    = reached_ff;
      predv_in      = predv_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      edge_idx_in   = edge_idx_ff;
      rsp_valid_in  = 1'b0;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      sum_in        = sum_ff;
      rsp_in        = rsp_ff;

      edge_we    = 1'b0;
      edge_waddr = edge_total_ff[EAW-1:0];
      edge_wdata = {req_data.edge_from[VW-1:0], req_data.edge_to[VW-1:0],
                    req_data.edge_weight[WB-1:0]};
      edge_re    = 1'b0;
      edge_raddr = edge_idx_ff[EAW-1:0];

      vt_we    = 1'b0;
      vt_waddr = e_to;
      vt_wdist = sum_ff;
      vt_wpred = best_idx_ff;
      vt_re    = 1'b0;
      vt_raddr = cur;

      alu_req.op  = ALU_LESS;
      alu_req.opa = vt_rdist;
      alu_req.opb = best_dist_ff;

      cand      = 1'b0;
      reach_out = reached_ff[cur];
      hp_out    = reach_out && predv_ff[cur];

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vcount_in = csr_wdata;
            CSR_SOURCE_VERTEX: source_in = csr_wdata[VERTEX_BITS-1:0];
            default:           vcount_in = vcount_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.has_edge) begin
               if ((CFG_COUNT_BITS'(req_data.edge_from) >= n_ext) ||
                   (CFG_COUNT_BITS'(req_data.edge_to) >= n_ext) ||
                   (edge_total_ff >= EW'(MAX_EDGES))) begin
                  drop_in = 1'b1;
               end else begin
                  edge_we       = 1'b1;
                  edge_total_in = edge_total_ff + EW'(1);
               end
            end
            if (accept && req_data.last_edge) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            settled_in = '0;
            reached_in = '0;
            predv_in   = '0;
            // source out of range leaves every vertex unreached
            if (CFG_COUNT_BITS'(source_ff) < n_ext) begin
               reached_in[source_ff[VW-1:0]] = 1'b1;
               vt_we    = 1'b1;
               vt_waddr = source_ff[VW-1:0];
               vt_wdist = '0;
               vt_wpred = '0;
            end
            idx_in   = '0;
            found_in = 1'b0;
            state_in = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            if (idx_ff == n_eff) begin
               idx_in   = '0;
               state_in = found_ff ? ST_SETTLE : ST_OUT_RD;
            end else begin
               vt_re    = 1'b1;
               state_in = ST_SEL_CMP;
            end
         end
         ST_SEL_CMP: begin
            // strict less keeps the lowest index on ties
            cand = reached_ff[cur] && !settled_ff[cur] && (!found_ff || alu_rsp.less);
            if (cand) begin
               best_dist_in = vt_rdist;
               best_idx_in  = cur;
               found_in     = 1'b1;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_SEL_RD;
         end
         ST_SETTLE: begin
            settled_in[best_idx_ff] = 1'b1;
            edge_idx_in = '0;
            state_in    = ST_EDGE_RD;
         end
         ST_EDGE_RD: begin
            if (edge_idx_ff == edge_total_ff) begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SEL_RD;
            end else begin
               edge_re  = 1'b1;
               state_in = ST_EDGE_CHK;
            end
         end
         ST_EDGE_CHK: begin
            if ((e_from == best_idx_ff) && (CW'(e_to) < n_eff) && !settled_ff[e_to]) begin
               vt_re    = 1'b1;
               vt_raddr = e_to;
               state_in = ST_EDGE_SUM;
            end else begin
               edge_idx_in = edge_idx_ff + EW'(1);
               state_in    = ST_EDGE_RD;
            end
         end
         ST_EDGE_SUM: begin
            alu_req.op  = ALU_ADD_SAT;
            alu_req.opa = best_dist_ff;
            alu_req.opb = DIST_BITS'(e_w);
            sum_in      = alu_rsp.sum;
            state_in    = ST_EDGE_UPD;
         end
         ST_EDGE_UPD: begin
            alu_req.opa = sum_ff;
            alu_req.opb = vt_rdist;
            // replace only on first reach or strict improvement
            if (!reached_ff[e_to] || alu_rsp.less) begin
               vt_we            = 1'b1;
               reached_in[e_to] = 1'b1;
               predv_in[e_to]   = 1'b1;
            end
            edge_idx_in = edge_idx_ff + EW'(1);
            state_in    = ST_EDGE_RD;
         end
         ST_OUT_RD: begin
            if (idx_ff == n_eff) begin
               // graph consumed: empty the store for the next one
               edge_total_in = '0;
               drop_in       = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               vt_re    = 1'b1;
               state_in = ST_OUT_EMIT;
            end
         end
         ST_OUT_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_in.vertex_index    = VERTEX_BITS'(cur);
            rsp_in.path_distance   = reach_out ? vt_rdist : '0;
            rsp_in.predecessor     = hp_out ? VERTEX_BITS'(vt_rpred) : '0;
            rsp_in.has_predecessor = hp_out;
            rsp_in.reachable       = reach_out;
            rsp_in.edges_dropped   = drop_ff;
            rsp_in.last_result     = (idx_ff + CW'(1)) == n_eff;
            idx_in                 = idx_ff + CW'(1);
            state_in               = ST_OUT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcount_ff     <= CFG_COUNT_BITS'(1);
         source_ff     <= '0;
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
         settled_ff    <= '0;
         reached_ff    <= '0;
         predv_ff      <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         edge_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         source_ff     <= source_in;
         edge_total_ff <= edge_total_in;
         drop_ff       <= drop_in;
         settled_ff    <= settled_in;
         reached_ff    <= reached_in;
         predv_ff      <= predv_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         edge_idx_ff   <= edge_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      sum_ff       <= sum_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // results only come out during a search
   `SSSP_ASSERT_HOLDS(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   // results are spaced by the table read
   `SSSP_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid)
   // a predecessor implies reachability
   `SSSP_ASSERT_HOLDS(a_pred_reach, clock, reset, rsp_valid && rsp_data.has_predecessor, rsp_data.reachable)
   // after the final item the store is emptied
   `SSSP_ASSERT_NEXT(a_last_clears, clock, reset, rsp_valid && rsp_data.last_result, edge_total_ff == '0 && !drop_ff)

endmodule
